@@ rtl/wpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// WAV PCM stream parser package
// Shared tags, result codes and the queue entry type.
// ----------------------------------------------------------------------------
package wpsp_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] OldRate = 32'd11025;
  localparam logic [7:0]  SignFlip = 8'h80;
  localparam logic [31:0] FmtLen  = 32'd16;

  // Configuration register indexes
  localparam logic RegKeepRate = 1'b0;
  localparam logic RegSwap     = 1'b1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RIFF     = 3'd1,
    ERR_WAVE     = 3'd2,
    ERR_FORMAT   = 3'd3,
    ERR_CHANNELS = 3'd4,
    ERR_BITS     = 3'd5,
    ERR_DATA     = 3'd6
  } err_e;

  // One front-end transaction; a pair entry expands to two results
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic        pair;
    err_e        err;
    logic        last;
    logic [31:0] rate;
    logic [4:0]  bits;
  } entry_t;

endpackage

@@ rtl/wav_pcm_stream_parser_top.sv @@
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// Takes a WAV file a byte at a time and emits converted PCM sample bytes.
// Usage:
//   Input channel: in_valid_i / in_stall_o with file_byte_i, one byte per
//   transaction. Output channel: out_valid_o / out_stall_i with kind, sample
//   byte, rate, bits, error code and last. Configuration: cfg_we_i writes
//   cfg_wdata_i to register cfg_idx_i (0 keep file rate, 1 swap_sixteen);
//   write only while the block is idle.
//   Throughput: one byte per cycle while in_stall_o is low. A swapped 16-bit
//   pair gives two results from its second byte, so the output also runs at
//   one result per cycle while out_stall_i is low. A byte's transaction is
//   queued, and its first result is then loaded into the output register.
//   A four-entry queue separates the header parser from the output stage;
//   when the receiver stalls, the queue fills and in_stall_o rises.
//   Reset clears the parser to expect the RIFF tag and empties the queue.
//   After the last result or an error, further bytes are taken and dropped.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  sample_byte_o,
  output logic [31:0] sample_rate_o,
  output logic [4:0]  sample_bits_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);
  import wpsp_pkg::*;

  logic   keep_rate_q, swap_q;
  logic   take, push, pop, empty, full, pending;
  entry_t ent_in, ent_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_rate_q <= 1'b1;
      swap_q      <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegKeepRate) keep_rate_q <= cfg_wdata_i;
      if (cfg_idx_i == RegSwap)     swap_q      <= cfg_wdata_i;
    end
  end

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  wpsp_front u_front (
    .clk_i, .rst_ni,
    .take_i         (take),
    .file_byte_i,
    .keep_rate_i    (keep_rate_q),
    .swap_sixteen_i (swap_q),
    .push_o         (push),
    .entry_o        (ent_in)
  );

  wpsp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .entry_i (ent_in),
    .pop_i   (pop),
    .entry_o (ent_out),
    .empty_o (empty),
    .full_o  (full)
  );

  wpsp_back u_back (
    .clk_i, .rst_ni,
    .entry_i       (ent_out),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_stall_i,
    .out_valid_o,
    .kind_o,
    .sample_byte_o,
    .sample_rate_o,
    .sample_bits_o,
    .error_code_o,
    .last_o,
    .pending_o     (pending)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !(push && !pop))
    else $error("push into full queue");

  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending |-> out_valid_o)
    else $error("pair half pending without valid output");

  a_no_pop_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending |-> !pop)
    else $error("pop while pair half pending");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_ERROR) |-> error_code_o == ERR_NONE)
    else $error("error code on non-error result");

endmodule

@@ rtl/wpsp_front.sv @@
// ----------------------------------------------------------------------------
// WAV PCM stream parser front end
// Walks the RIFF header and chunks; sample bytes, data end and errors become transactions.
// ----------------------------------------------------------------------------
module wpsp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      file_byte_i,
  input  logic            keep_rate_i,
  input  logic            swap_sixteen_i,
  output logic            push_o,
  output wpsp_pkg::entry_t entry_o
);
  import wpsp_pkg::*;

  localparam logic [3:0] PH_RIFF   = 4'd0;
  localparam logic [3:0] PH_RSIZE  = 4'd1;
  localparam logic [3:0] PH_WAVE   = 4'd2;
  localparam logic [3:0] PH_TAG    = 4'd3;
  localparam logic [3:0] PH_SIZE   = 4'd4;
  localparam logic [3:0] PH_FORMAT = 4'd5;
  localparam logic [3:0] PH_CHAN   = 4'd6;
  localparam logic [3:0] PH_RATE   = 4'd7;
  localparam logic [3:0] PH_AVG    = 4'd8;
  localparam logic [3:0] PH_ALIGN  = 4'd9;
  localparam logic [3:0] PH_BITS   = 4'd10;
  localparam logic [3:0] PH_SKIP   = 4'd11;
  localparam logic [3:0] PH_DATA   = 4'd12;
  localparam logic [3:0] PH_HALT   = 4'd13;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  bp_q, bp_d;
  logic [31:0] aw_q, aw_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rate_q, rate_d;
  logic        fmt_q, fmt_d;
  logic [7:0]  held_q, held_d;

  logic        done4, done2, first, fin;
  logic [31:0] rem_dec;
  entry_t      ent;
  logic        push;

  always_comb begin
    phase_d = phase_q;
    bp_d    = bp_q;
    aw_d    = aw_q;
    tag_d   = tag_q;
    rem_d   = rem_q;
    bits_d  = bits_q;
    rate_d  = rate_q;
    fmt_d   = fmt_q;
    held_d  = held_q;
    push    = 1'b0;
    ent     = '0;
    ent.kind = KIND_SAMPLE;
    ent.err  = ERR_NONE;
    done4   = 1'b0;
    done2   = 1'b0;
    rem_dec = rem_q - 32'd1;
    first   = ~rem_q[0];
    fin     = (rem_dec == 32'd0);

    if (take_i && phase_q != PH_HALT) begin
      if (phase_q != PH_SKIP && phase_q != PH_DATA) begin
        aw_d  = {file_byte_i, aw_q[31:8]};
        done4 = (bp_q == 2'd3);
        done2 = (bp_q != 2'd0);
      end
      unique case (phase_q)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_TAG, PH_SIZE, PH_RATE, PH_AVG: begin
          bp_d = done4 ? 2'd0 : bp_q + 2'd1;
        end
        PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS: begin
          bp_d = done2 ? 2'd0 : 2'd1;
        end
        default: ;
      endcase

      unique case (phase_q)
        PH_RIFF: if (done4) begin
          if (aw_d != TagRiff) begin
            push = 1'b1; ent.kind = KIND_ERROR; ent.err = ERR_RIFF; phase_d = PH_HALT;
          end else begin
            phase_d = PH_RSIZE;
          end
        end
        PH_RSIZE: if (done4) phase_d = PH_WAVE;
        PH_WAVE: if (done4) begin
          if (aw_d != TagWave) begin
            push = 1'b1; ent.kind = KIND_ERROR; ent.err = ERR_WAVE; phase_d = PH_HALT;
          end else begin
            phase_d = PH_TAG;
          end
        end
        PH_TAG: if (done4) begin
          tag_d   = aw_d;
          phase_d = PH_SIZE;
        end
        PH_SIZE: if (done4) begin
          if (tag_q == TagFmt) begin
            rem_d   = (aw_d >= FmtLen) ? aw_d - FmtLen : 32'd0;
            phase_d = PH_FORMAT;
          end else if (tag_q == TagData) begin
            if (!fmt_q || (bits_q == 16'd16 && aw_d[0])) begin
              push = 1'b1; ent.kind = KIND_ERROR; ent.err = ERR_DATA; phase_d = PH_HALT;
            end else if (aw_d == 32'd0) begin
              push = 1'b1; ent.kind = KIND_DONE; phase_d = PH_HALT;
            end else begin
              rem_d   = aw_d;
              phase_d = PH_DATA;
            end
          end else begin
            rem_d   = aw_d;
            phase_d = (aw_d != 32'd0) ? PH_SKIP : PH_TAG;
          end
        end
        PH_FORMAT: if (done2) begin
          if (aw_d[31:16] != 16'd1) begin
            push = 1'b1; ent.kind = KIND_ERROR; ent.err = ERR_FORMAT; phase_d = PH_HALT;
          end else begin
            phase_d = PH_CHAN;
          end
        end
        PH_CHAN: if (done2) begin
          if (aw_d[31:16] != 16'd1) begin
            push = 1'b1; ent.kind = KIND_ERROR; ent.err = ERR_CHANNELS; phase_d = PH_HALT;
          end else begin
            phase_d = PH_RATE;
          end
        end
        PH_RATE: if (done4) begin
          rate_d  = keep_rate_i ? aw_d : OldRate;
          phase_d = PH_AVG;
        end
        PH_AVG: if (done4) phase_d = PH_ALIGN;
        PH_ALIGN: if (done2) phase_d = PH_BITS;
        PH_BITS: if (done2) begin
          bits_d = aw_d[31:16];
          if (aw_d[31:16] != 16'd8 && aw_d[31:16] != 16'd16) begin
            push = 1'b1; ent.kind = KIND_ERROR; ent.err = ERR_BITS; phase_d = PH_HALT;
          end else begin
            fmt_d   = 1'b1;
            phase_d = (rem_q != 32'd0) ? PH_SKIP : PH_TAG;
          end
        end
        PH_SKIP: begin
          rem_d = rem_dec;
          if (fin) phase_d = PH_TAG;
        end
        PH_DATA: begin
          rem_d = rem_dec;
          if (fin) phase_d = PH_HALT;
          if (bits_q != 16'd16) begin
            push = 1'b1; ent.byte0 = file_byte_i ^ SignFlip; ent.last = fin;
          end else if (first && swap_sixteen_i) begin
            // hold the low byte until its partner arrives
            held_d = file_byte_i;
            bp_d   = 2'd1;
          end else if (!first && bp_q == 2'd1) begin
            bp_d = 2'd0;
            push = 1'b1; ent.pair = 1'b1;
            ent.byte0 = file_byte_i; ent.byte1 = held_q; ent.last = fin;
          end else begin
            push = 1'b1; ent.byte0 = file_byte_i; ent.last = fin;
          end
        end
        default: ;
      endcase
      if (ent.kind != KIND_SAMPLE) ent.last = 1'b1;
    end
    ent.rate = rate_d;
    ent.bits = bits_d[4:0];
  end

  assign push_o  = push;
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      bp_q    <= '0;
      aw_q    <= '0;
      tag_q   <= '0;
      rem_q   <= '0;
      bits_q  <= '0;
      rate_q  <= '0;
      fmt_q   <= 1'b0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      bp_q    <= bp_d;
      aw_q    <= aw_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
      bits_q  <= bits_d;
      rate_q  <= rate_d;
      fmt_q   <= fmt_d;
      held_q  <= held_d;
    end
  end

endmodule

@@ rtl/wpsp_queue.sv @@
// ----------------------------------------------------------------------------
// WAV PCM stream parser queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module wpsp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wpsp_pkg::entry_t entry_i,
  input  logic             pop_i,
  output wpsp_pkg::entry_t entry_o,
  output logic             empty_o,
  output logic             full_o
);
  import wpsp_pkg::*;

  entry_t               mem_q [QDepth];
  logic [QPtrW-1:0]     wr_q, rd_q;
  logic [QPtrW:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign entry_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + (QPtrW+1)'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - (QPtrW+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/wpsp_back.sv @@
// ----------------------------------------------------------------------------
// WAV PCM stream parser back end
// Expands queued transactions into results and holds the output register.
// ----------------------------------------------------------------------------
module wpsp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wpsp_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [1:0]       kind_o,
  output logic [7:0]       sample_byte_o,
  output logic [31:0]      sample_rate_o,
  output logic [4:0]       sample_bits_o,
  output logic [2:0]       error_code_o,
  output logic             last_o,
  output logic             pending_o
);
  import wpsp_pkg::*;

  logic       valid_q;
  logic       pend_q;
  entry_t     out_q, out_d;
  logic [7:0] byte_q, byte_d;
  logic       adv;

  assign adv   = !valid_q || !out_stall_i;
  assign pop_o = adv && !pend_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (adv) begin
      valid_q <= pend_q || !empty_i;
      pend_q  <= !pend_q && !empty_i && entry_i.pair;
    end
  end

  always_comb begin
    out_d  = out_q;
    byte_d = byte_q;
    if (adv) begin
      if (pend_q) begin
        // second half of a swapped pair
        byte_d     = out_q.byte1;
        out_d.last = out_q.pair;
        out_d.pair = 1'b0;
      end else if (!empty_i) begin
        out_d      = entry_i;
        byte_d     = entry_i.byte0;
        out_d.last = entry_i.pair ? 1'b0 : entry_i.last;
        out_d.pair = entry_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    byte_q <= byte_d;
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = out_q.kind;
  assign sample_byte_o = byte_q;
  assign sample_rate_o = out_q.rate;
  assign sample_bits_o = out_q.bits;
  assign error_code_o  = out_q.err;
  assign last_o        = out_q.last;
  assign pending_o     = pend_q;

endmodule
